[rtl/atrd_pkg.sv]
// ----------------------------------------------------------------------------
// atrd_pkg
// Shared types, character codes and match tables for the AT response
// terminator detector.
// ----------------------------------------------------------------------------
package atrd_pkg;

  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned BUFFER_BYTES = 1024;
  localparam logic [COUNT_W-1:0] BUFFER_COUNT = COUNT_W'(BUFFER_BYTES);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [2:0] LINE_LEN_MAX = 3'd7;
  localparam logic [2:0] OK_LINE_LEN  = 3'd3;  // "OK" plus trailing CR
  localparam logic [2:0] ERR_LINE_LEN = 3'd5;  // "ERROR"

  typedef enum logic [1:0] {
    STATUS_PENDING = 2'd0,
    STATUS_OK      = 2'd1,
    STATUS_ERROR   = 2'd2
  } status_t;

  // One item moving from the input register into the state update
  typedef struct packed {
    logic       en;
    logic       clear;
    logic [7:0] data;
  } step_t;

  // Expected characters of the OK line, by position
  function automatic logic [7:0] ok_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = 8'h4F;  // O
      2'd1:    c = 8'h4B;  // K
      default: c = CH_CR;
    endcase
    return c;
  endfunction

  // Expected characters of the ERROR prefix, by position
  function automatic logic [7:0] err_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0, 3'd3: c = 8'h45;  // E (position 0), O below
      default:    c = 8'h52;  // R
    endcase
    if (pos == 3'd3) begin
      c = 8'h4F;
    end
    return c;
  endfunction

endpackage

[rtl/atrd_line_detect.sv]
// ----------------------------------------------------------------------------
// atrd_line_detect
// Line tracker: CR LF framing, OK / ERROR line matching and status latch.
// ----------------------------------------------------------------------------
module atrd_line_detect (
  input  logic             clk,
  input  logic             rst,
  input  atrd_pkg::step_t  step,
  output logic             done,
  output atrd_pkg::status_t status_next,
  output logic             pending
);
  import atrd_pkg::*;

  logic       prev_was_cr,        prev_was_cr_next;
  logic       seen_line_end,      seen_line_end_next;
  logic [2:0] line_length,        line_length_next;
  logic       ok_prefix_match,    ok_prefix_match_next;
  logic       error_prefix_match, error_prefix_match_next;
  status_t    latched_status;

  logic line_end;
  logic hit_ok;
  logic hit_err;

  assign pending  = (latched_status == STATUS_PENDING);
  assign line_end = (step.data == CH_LF) && prev_was_cr;
  assign hit_ok   = seen_line_end && (line_length == OK_LINE_LEN) && ok_prefix_match;
  assign hit_err  = seen_line_end && (line_length >= ERR_LINE_LEN) && error_prefix_match;

  always_comb begin
    prev_was_cr_next        = prev_was_cr;
    seen_line_end_next      = seen_line_end;
    line_length_next        = line_length;
    ok_prefix_match_next    = ok_prefix_match;
    error_prefix_match_next = error_prefix_match;
    status_next             = latched_status;
    done                    = 1'b0;
    if (step.clear) begin
      prev_was_cr_next        = 1'b0;
      seen_line_end_next      = 1'b0;
      line_length_next        = '0;
      ok_prefix_match_next    = 1'b1;
      error_prefix_match_next = 1'b1;
      status_next             = STATUS_PENDING;
    end else if (pending) begin
      if (line_end) begin
        priority if (hit_ok) begin
          status_next = STATUS_OK;
          done        = 1'b1;
        end else if (hit_err) begin
          status_next = STATUS_ERROR;
          done        = 1'b1;
        end else begin
          seen_line_end_next      = 1'b1;
          line_length_next        = '0;
          ok_prefix_match_next    = 1'b1;
          error_prefix_match_next = 1'b1;
        end
        prev_was_cr_next = 1'b0;
      end else begin
        ok_prefix_match_next = ok_prefix_match && (line_length < OK_LINE_LEN)
                               && (step.data == ok_char(line_length[1:0]));
        if (line_length < ERR_LINE_LEN && step.data != err_char(line_length)) begin
          error_prefix_match_next = 1'b0;
        end
        if (line_length != LINE_LEN_MAX) begin
          line_length_next = line_length + 3'd1;
        end
        prev_was_cr_next = (step.data == CH_CR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_was_cr        <= 1'b0;
      seen_line_end      <= 1'b0;
      line_length        <= '0;
      ok_prefix_match    <= 1'b1;
      error_prefix_match <= 1'b1;
      latched_status     <= STATUS_PENDING;
    end else if (step.en) begin
      prev_was_cr        <= prev_was_cr_next;
      seen_line_end      <= seen_line_end_next;
      line_length        <= line_length_next;
      ok_prefix_match    <= ok_prefix_match_next;
      error_prefix_match <= error_prefix_match_next;
      latched_status     <= status_next;
    end
  end

  // OK can only match on a line of exactly OK_LINE_LEN
  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    (line_length > OK_LINE_LEN) |-> !ok_prefix_match)
    else $error("ok match kept past OK line length");

  // status never moves once latched, except on a clear
  a_latch: assert property (@(posedge clk) disable iff (rst)
    (step.en && !step.clear && !pending) |=> $stable(latched_status))
    else $error("latched status changed without clear");

  // a finished response leaves a non-pending status
  a_done: assert property (@(posedge clk) disable iff (rst)
    (step.en && done) |=> !pending)
    else $error("done without latched status");

endmodule

[rtl/atrd_byte_count.sv]
// ----------------------------------------------------------------------------
// atrd_byte_count
// Saturating response byte counter with overflow flag.
// ----------------------------------------------------------------------------
module atrd_byte_count (
  input  logic                          clk,
  input  logic                          rst,
  input  atrd_pkg::step_t               step,
  input  logic                          pending,
  output logic [atrd_pkg::COUNT_W-1:0]  count_next,
  output logic                          overflow_next
);
  import atrd_pkg::*;

  logic [COUNT_W-1:0] byte_count;
  logic               overflow_flag;

  always_comb begin
    count_next    = byte_count;
    overflow_next = overflow_flag;
    if (step.clear) begin
      count_next    = '0;
      overflow_next = 1'b0;
    end else if (pending) begin
      if (byte_count == BUFFER_COUNT) begin
        overflow_next = 1'b1;
      end else begin
        count_next = byte_count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      overflow_flag <= 1'b0;
    end else if (step.en) begin
      byte_count    <= count_next;
      overflow_flag <= overflow_next;
    end
  end

  a_sat: assert property (@(posedge clk) disable iff (rst)
    byte_count <= BUFFER_COUNT)
    else $error("byte count beyond buffer size");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> (byte_count == BUFFER_COUNT))
    else $error("overflow without full count");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (step.en && step.clear) |=> (byte_count == '0 && !overflow_flag))
    else $error("clear did not zero the counter");

endmodule

[rtl/at_response_terminator_detector_top.sv]
// ----------------------------------------------------------------------------
// at_response_terminator_detector_top
// Follows a modem's AT response byte by byte and flags OK / ERROR endings.
// ----------------------------------------------------------------------------
// Each item is either a clear (command = 1) that starts a new response or
// one received byte (command = 0). Every item yields exactly one result
// carrying complete, status, bytes_received and overflow. Lines are framed
// by CR LF; after at least one earlier CR LF, a line that reads exactly OK
// ends the response with status ok, and a line starting ERROR ends it with
// status error. The status then holds and later bytes are ignored until the
// next clear. The byte count saturates at 1024 and sets overflow.
// Throughput is one item per clock: an item waits in the input register, the
// state update and result are computed in one pass of small compare logic,
// and the result register holds it until taken, so out_valid rises when the
// item moves from the input register into the result register. Only output
// back-pressure slows the block.
// ----------------------------------------------------------------------------
module at_response_terminator_detector_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          complete,
  output logic [1:0]                    status,
  output logic [atrd_pkg::COUNT_W-1:0]  bytes_received,
  output logic                          overflow
);
  import atrd_pkg::*;

  // input register
  logic       s1_valid;
  logic       s1_command;
  logic [7:0] s1_data;

  logic    s2_load;   // result register can take a new item
  step_t   step;
  logic    done;
  status_t status_next;
  logic    pending;
  logic [COUNT_W-1:0] count_next;
  logic    overflow_next;

  assign s2_load  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_load;

  assign step.en    = s1_valid && s2_load;
  assign step.clear = s1_command;
  assign step.data  = s1_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_command <= command;
      s1_data    <= data_byte;
    end
  end

  atrd_line_detect u_line (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .done        (done),
    .status_next (status_next),
    .pending     (pending)
  );

  atrd_byte_count u_count (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .pending       (pending),
    .count_next    (count_next),
    .overflow_next (overflow_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.en) begin
      complete       <= done;
      status         <= status_next;
      bytes_received <= count_next;
      overflow       <= overflow_next;
    end
  end

  a_complete: assert property (@(posedge clk) disable iff (rst)
    (out_valid && complete) |-> (status != STATUS_PENDING))
    else $error("complete with pending status");

  a_ovf_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (bytes_received == BUFFER_COUNT))
    else $error("overflow shown without full count");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid))
    else $error("input stalled with free pipeline");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_load) |=> (s1_valid && $stable(s1_data) && $stable(s1_command)))
    else $error("stalled item lost from input register");

endmodule
